// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the multipop stack block.
// Depends on nothing; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising edge while reset is released.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLKD(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== hdl/mpst_pkg.sv =====
// Types and constants of the multipop stack with cost tracking.
// Has no dependencies; used by multipop_stack_cost_tracker.
package mpst_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned POT_W = 5;

  localparam logic [1:0] OP_PUSH     = 2'd0;
  localparam logic [1:0] OP_MULTIPOP = 2'd1;
  localparam logic [1:0] OP_DUMP     = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } mpst_state_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] push_value;
    logic [CNT_W-1:0]        pop_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic                    has_data;
    logic signed [VAL_W-1:0] data_value;
    logic                    last;
    logic [POT_W-1:0]        potential;
    logic [31:0]             amortized_total;
    logic [31:0]             actual_total;
  } out_item_t;

endpackage

// ===== hdl/multipop_stack_cost_tracker.sv =====
// Multipop stack with cost tracking: bounded LIFO, push, multipop and dump.
// Depends on mpst_pkg and assert_macros.svh.
//
// Usage:
//   The input channel (in_valid, in_ready, in_data) takes one operation per
//   transaction: push a value, pop up to pop_count values, or dump the whole
//   stack from top to bottom. The result channel (out_valid, out_ready,
//   out_data) returns one transaction per popped or dumped element, or a
//   single status transaction for a push, an ignored opcode, a zero count or
//   an overflow/underflow. The final result of an operation has last set.
//   A push or single-status operation is accepted and its result
//   registered in the same cycle, so it shows on out_valid in the next
//   cycle. Multipop and dump run a sequencer over the stack memory, whose
//   registered read port sets the pace: each element is read in S_READ
//   and emitted in S_EMIT, for up to STACK_DEPTH elements per operation.
//   The block takes one operation at a time and lowers in_ready until the
//   last result has been loaded.
//   When the receiver stalls, the output register holds its transaction
//   and the sequencer waits; nothing is lost or repeated.
//   Reset (synchronous, active low) empties the stack and clears both cost
//   totals; stack memory contents are not cleared.
module multipop_stack_cost_tracker
  import mpst_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

`include "assert_macros.svh"

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

  mpst_state_t state_r, state_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          pop_mode_r, pop_mode_nxt;
  logic [31:0]   amort_r, amort_nxt;
  logic [31:0]   actual_r, actual_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic [VAL_W-1:0] mem [STACK_DEPTH];
  logic [VAL_W-1:0] rdata_r;
  logic             mem_we;
  logic             out_free;
  logic [DW-1:0]    pop_k;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [1:0] inc);
    logic [31:0] inc_w;
    inc_w = 32'(inc);
    return (a > (SUM_MAX - inc_w)) ? SUM_MAX : a + inc_w;
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign pop_k    = (9'(in_data.pop_count) < 9'(depth_r)) ? DW'(in_data.pop_count) : depth_r;

  // Stack memory: one write port for pushes, one registered read port
  // addressed by the element pointer.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[depth_r[AW-1:0]] <= in_data.push_value;
    end
    rdata_r <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      rem_r       <= '0;
      ptr_r       <= '0;
      pop_mode_r  <= 1'b0;
      amort_r     <= '0;
      actual_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      rem_r       <= rem_nxt;
      ptr_r       <= ptr_nxt;
      pop_mode_r  <= pop_mode_nxt;
      amort_r     <= amort_nxt;
      actual_r    <= actual_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    rem_nxt       = rem_r;
    ptr_nxt       = ptr_r;
    pop_mode_nxt  = pop_mode_r;
    amort_nxt     = amort_r;
    actual_nxt    = actual_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    in_ready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          out_nxt.status     = ST_OK;
          out_nxt.has_data   = 1'b0;
          out_nxt.data_value = '0;
          out_nxt.last       = 1'b1;
          out_valid_nxt      = 1'b1;
          unique case (in_data.opcode)
            OP_PUSH: begin
              if (depth_r == DEPTH_FULL) begin
                out_nxt.status = ST_OVERFLOW;
              end else begin
                mem_we     = 1'b1;
                depth_nxt  = depth_r + 1'b1;
                amort_nxt  = sat_add(amort_r, 2'd2);
                actual_nxt = sat_add(actual_r, 2'd1);
              end
            end
            OP_MULTIPOP, OP_DUMP: begin
              if (depth_r == '0) begin
                out_nxt.status = ST_UNDERFLOW;
              end else if (in_data.opcode == OP_MULTIPOP && pop_k == '0) begin
                out_nxt.status = ST_OK;
              end else begin
                // Elements go out from the sequencer; nothing is loaded now.
                out_valid_nxt = out_valid_r && !out_ready;
                out_nxt       = out_r;
                pop_mode_nxt  = (in_data.opcode == OP_MULTIPOP);
                rem_nxt       = (in_data.opcode == OP_MULTIPOP) ? pop_k : depth_r;
                ptr_nxt       = AW'(depth_r - 1'b1);
                state_nxt     = S_READ;
              end
            end
            default: begin
              out_nxt.status = ST_OK;
            end
          endcase
          if (state_nxt == S_IDLE) begin
            out_nxt.potential       = POT_W'(depth_nxt);
            out_nxt.amortized_total = amort_nxt;
            out_nxt.actual_total    = actual_nxt;
          end
        end
      end

      S_READ: begin
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          if (pop_mode_r) begin
            depth_nxt  = depth_r - 1'b1;
            actual_nxt = sat_add(actual_r, 2'd1);
          end
          out_valid_nxt           = 1'b1;
          out_nxt.status          = ST_OK;
          out_nxt.has_data        = 1'b1;
          out_nxt.data_value      = rdata_r;
          out_nxt.last            = (rem_r == DW'(1));
          out_nxt.potential       = POT_W'(depth_nxt);
          out_nxt.amortized_total = amort_r;
          out_nxt.actual_total    = actual_nxt;
          rem_nxt                 = rem_r - 1'b1;
          ptr_nxt                 = ptr_r - 1'b1;
          state_nxt               = (rem_r == DW'(1)) ? S_IDLE : S_READ;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_CLKD(a_depth_bound, depth_r <= DEPTH_FULL, "stack depth beyond capacity")
  `ASSERT_CLKD(a_busy_has_work, (state_r != S_IDLE) |-> (rem_r != '0), "sequencer busy with no elements left")
  `ASSERT_CLKD(a_data_status_ok, (out_valid_r && out_r.has_data) |-> (out_r.status == ST_OK), "element delivered with error status")
  `ASSERT_CLKD(a_actual_monotonic, $past(rst_n) |-> (actual_r >= $past(actual_r)), "actual cost total decreased")
  `ASSERT_CLKD(a_pop_shrinks, (state_r == S_EMIT && out_free && pop_mode_r) |=> (depth_r == $past(depth_r) - 1'b1), "popped element did not reduce depth")
  `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "block not idle after reset")

endmodule
